/* hw/rtl/cst_pkg.sv */
// Shared types, token codes and the keyword table for the C source tokenizer.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none
package cst_pkg;

  localparam int POSITION_BITS_DEF     = 32;
  localparam int LENGTH_BITS_DEF       = 16;
  localparam int KEYWORD_MAX_CHARS_DEF = 14;

  localparam int KIND_BITS  = 7;
  localparam int ERR_BITS   = 2;
  localparam int KW_COUNT   = 44;
  localparam int KW_CHARS   = 14;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Lexer modes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_OP1   = 4'd1,
    M_OP2   = 4'd2,
    M_DEC   = 4'd3,
    M_ZERO  = 4'd4,
    M_OCT   = 4'd5,
    M_HEX   = 4'd6,
    M_IDENT = 4'd7,
    M_STR   = 4'd8,
    M_CHR   = 4'd9,
    M_LINE  = 4'd10,
    M_BLOCK = 4'd11,
    M_STAR  = 4'd12
  } mode_t;

  // Token kinds
  localparam logic [6:0] K_ILLEGAL = 7'd0;
  localparam logic [6:0] K_EOF     = 7'd1;
  localparam logic [6:0] K_HASH    = 7'd2;
  localparam logic [6:0] K_LPAREN  = 7'd3;
  localparam logic [6:0] K_RPAREN  = 7'd4;
  localparam logic [6:0] K_LBRACK  = 7'd5;
  localparam logic [6:0] K_RBRACK  = 7'd6;
  localparam logic [6:0] K_LBRACE  = 7'd7;
  localparam logic [6:0] K_RBRACE  = 7'd8;
  localparam logic [6:0] K_COLON   = 7'd9;
  localparam logic [6:0] K_SEMI    = 7'd10;
  localparam logic [6:0] K_DOT     = 7'd11;
  localparam logic [6:0] K_COMMA   = 7'd12;
  localparam logic [6:0] K_PLUS    = 7'd13;
  localparam logic [6:0] K_INC     = 7'd14;
  localparam logic [6:0] K_PLUSEQ  = 7'd15;
  localparam logic [6:0] K_MINUS   = 7'd16;
  localparam logic [6:0] K_DEC     = 7'd17;
  localparam logic [6:0] K_MINUSEQ = 7'd18;
  localparam logic [6:0] K_ARROW   = 7'd19;
  localparam logic [6:0] K_STAR    = 7'd20;
  localparam logic [6:0] K_STAREQ  = 7'd21;
  localparam logic [6:0] K_PCT     = 7'd22;
  localparam logic [6:0] K_PCTEQ   = 7'd23;
  localparam logic [6:0] K_ASSIGN  = 7'd24;
  localparam logic [6:0] K_EQ      = 7'd25;
  localparam logic [6:0] K_NOT     = 7'd26;
  localparam logic [6:0] K_NE      = 7'd27;
  localparam logic [6:0] K_AND     = 7'd28;
  localparam logic [6:0] K_LAND    = 7'd29;
  localparam logic [6:0] K_ANDEQ   = 7'd30;
  localparam logic [6:0] K_XOR     = 7'd31;
  localparam logic [6:0] K_XOREQ   = 7'd32;
  localparam logic [6:0] K_OR      = 7'd33;
  localparam logic [6:0] K_LOR     = 7'd34;
  localparam logic [6:0] K_OREQ    = 7'd35;
  localparam logic [6:0] K_SLASH   = 7'd36;
  localparam logic [6:0] K_SLASHEQ = 7'd37;
  localparam logic [6:0] K_LT      = 7'd38;
  localparam logic [6:0] K_LE      = 7'd39;
  localparam logic [6:0] K_SHL     = 7'd40;
  localparam logic [6:0] K_SHLEQ   = 7'd41;
  localparam logic [6:0] K_GT      = 7'd42;
  localparam logic [6:0] K_GE      = 7'd43;
  localparam logic [6:0] K_SHR     = 7'd44;
  localparam logic [6:0] K_SHREQ   = 7'd45;
  localparam logic [6:0] K_NUM     = 7'd46;
  localparam logic [6:0] K_STR     = 7'd47;
  localparam logic [6:0] K_CH      = 7'd48;
  localparam logic [6:0] K_IDENT   = 7'd49;
  localparam logic [6:0] K_KW0     = 7'd50;

  // Error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_EMPTY   = 2'd1;
  localparam logic [1:0] E_UNTERM  = 2'd2;
  localparam logic [1:0] E_UNKNOWN = 2'd3;

  // Result pushes from the lexer into the output queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  // Keyword text, right-justified, first character in the high byte
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
    "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
    {"_Static", "_assert"}, {"_Thread", "_local"}};

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd4, 5'd5, 5'd4, 5'd4, 5'd5, 5'd8, 5'd7, 5'd2, 5'd6, 5'd4, 5'd4,
    5'd6, 5'd5, 5'd3, 5'd4, 5'd2, 5'd6, 5'd3, 5'd4, 5'd8, 5'd8, 5'd6,
    5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd7, 5'd5, 5'd8, 5'd4, 5'd8,
    5'd5, 5'd8, 5'd8, 5'd7, 5'd5, 5'd8, 5'd8, 5'd10, 5'd9, 5'd14, 5'd13};

  // Character j of keyword i (only meaningful below its length)
  function automatic logic [7:0] kw_char(input int i, input int j);
    logic [8*KW_CHARS-1:0] t;
    int                    sh;
    t  = KW_TEXT[i];
    sh = (int'(KW_LEN[i]) - 1 - j) * 8;
    if (sh < 0) begin
      return 8'h00;
    end
    return 8'(t >> sh);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= "0") && (c <= "7");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "%") || (c == "=") ||
           (c == "!") || (c == "&") || (c == "^") || (c == "|") || (c == "/") ||
           (c == "<") || (c == ">");
  endfunction

  function automatic logic [6:0] op_single(input logic [7:0] h);
    case (h)
      "+":     return K_PLUS;
      "-":     return K_MINUS;
      "*":     return K_STAR;
      "%":     return K_PCT;
      "=":     return K_ASSIGN;
      "!":     return K_NOT;
      "&":     return K_AND;
      "^":     return K_XOR;
      "|":     return K_OR;
      "/":     return K_SLASH;
      "<":     return K_LT;
      default: return K_GT;
    endcase
  endfunction

  // Two-character operator: bit 7 set when h,c form one
  function automatic logic [7:0] op_double(input logic [7:0] h, input logic [7:0] c);
    if (c == "=") begin
      case (h)
        "+":     return {1'b1, K_PLUSEQ};
        "-":     return {1'b1, K_MINUSEQ};
        "*":     return {1'b1, K_STAREQ};
        "%":     return {1'b1, K_PCTEQ};
        "=":     return {1'b1, K_EQ};
        "!":     return {1'b1, K_NE};
        "&":     return {1'b1, K_ANDEQ};
        "^":     return {1'b1, K_XOREQ};
        "|":     return {1'b1, K_OREQ};
        "/":     return {1'b1, K_SLASHEQ};
        "<":     return {1'b1, K_LE};
        ">":     return {1'b1, K_GE};
        default: return 8'h00;
      endcase
    end
    if (c == h) begin
      if (h == "+") return {1'b1, K_INC};
      if (h == "-") return {1'b1, K_DEC};
      if (h == "&") return {1'b1, K_LAND};
      if (h == "|") return {1'b1, K_LOR};
    end
    if ((h == "-") && (c == ">")) return {1'b1, K_ARROW};
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cst_kw_match.sv */
// Keyword lookup: compares the held identifier prefix against all keywords
// in parallel. Depends on cst_pkg for the keyword table and token codes.
`default_nettype none
module cst_kw_match #(
  parameter int POSITION_BITS     = cst_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_MAX_CHARS = cst_pkg::KEYWORD_MAX_CHARS_DEF
) (
  input  wire logic [KEYWORD_MAX_CHARS-1:0][7:0] ident_buf,
  input  wire logic [POSITION_BITS:0]            ident_len,
  input  wire logic                              too_long,
  output logic      [6:0]                        kind
);

  logic [cst_pkg::KW_COUNT-1:0] hit;

  // Match every keyword at once; keywords are distinct so at most one hits
  always_comb begin
    for (int i = 0; i < cst_pkg::KW_COUNT; i++) begin
      hit[i] = (ident_len == (POSITION_BITS+1)'(cst_pkg::KW_LEN[i]));
      for (int j = 0; j < cst_pkg::KW_CHARS; j++) begin
        if (j < int'(cst_pkg::KW_LEN[i])) begin
          hit[i] = hit[i] && (ident_buf[j] == cst_pkg::kw_char(i, j));
        end
      end
    end
  end

  // Encode the hit or fall back to identifier
  always_comb begin
    kind = cst_pkg::K_IDENT;
    if (!too_long && (ident_len <= (POSITION_BITS+1)'(KEYWORD_MAX_CHARS))) begin
      for (int i = 0; i < cst_pkg::KW_COUNT; i++) begin
        if (hit[i]) begin
          kind = cst_pkg::K_KW0 + 7'(i);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cst_lexer.sv */
// Lexer core: mode state, positions and identifier buffer; turns one byte
// into up to two results. Depends on cst_pkg and cst_kw_match.
`default_nettype none
module cst_lexer #(
  parameter int POSITION_BITS     = cst_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS       = cst_pkg::LENGTH_BITS_DEF,
  parameter int KEYWORD_MAX_CHARS = cst_pkg::KEYWORD_MAX_CHARS_DEF,
  localparam int RES_W = cst_pkg::KIND_BITS + POSITION_BITS + LENGTH_BITS +
                         cst_pkg::ERR_BITS + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         src_byte,
  output cst_pkg::push_t          push,
  output logic      [RES_W-1:0]   res0,
  output logic      [RES_W-1:0]   res1
);

  localparam int SPAN_W = POSITION_BITS + 1;
  localparam int CMP_W  = (SPAN_W > LENGTH_BITS) ? SPAN_W : LENGTH_BITS;
  localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'({LENGTH_BITS{1'b1}});

  cst_pkg::mode_t                      mode_r, mode_nxt;
  logic [7:0]                          held_r, held_nxt;
  logic [POSITION_BITS-1:0]            pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]            start_r, start_nxt;
  logic                                too_long_r, too_long_nxt;
  logic                                blk_open_r, blk_open_nxt;
  logic [KEYWORD_MAX_CHARS-1:0][7:0]   buf_r;
  logic                                buf_we;
  logic [$clog2(KEYWORD_MAX_CHARS)-1:0] buf_idx;

  logic [SPAN_W-1:0] n_ex, n_in;
  logic [6:0]        kw_kind;
  logic [7:0]        dbl;
  logic              again, ended;

  logic              c_v, s_v;
  logic [6:0]        c_kind, s_kind;
  logic [POSITION_BITS-1:0] c_start;
  logic [SPAN_W-1:0] c_len, s_len;
  logic [1:0]        c_err, s_err;

  function automatic logic [LENGTH_BITS-1:0] sat(input logic [SPAN_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w > LEN_MAX) begin
      return {LENGTH_BITS{1'b1}};
    end
    return LENGTH_BITS'(w);
  endfunction

  assign n_ex = {1'b0, pos_r - start_r};
  assign n_in = n_ex + SPAN_W'(1);
  assign dbl  = cst_pkg::op_double(held_r, src_byte);

  cst_kw_match #(
    .POSITION_BITS     (POSITION_BITS),
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
  ) u_kw (
    .ident_buf (buf_r),
    .ident_len (n_ex),
    .too_long  (too_long_r),
    .kind      (kw_kind)
  );

  // Close the pending token, then start a new one from the same byte
  always_comb begin
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    start_nxt    = start_r;
    too_long_nxt = too_long_r;
    blk_open_nxt = blk_open_r;
    buf_we       = 1'b0;
    buf_idx      = '0;
    again        = 1'b0;
    ended        = 1'b0;
    c_v          = 1'b0;
    c_kind       = cst_pkg::K_ILLEGAL;
    c_start      = start_r;
    c_len        = n_ex;
    c_err        = cst_pkg::E_NONE;
    s_v          = 1'b0;
    s_kind       = cst_pkg::K_ILLEGAL;
    s_len        = SPAN_W'(1);
    s_err        = cst_pkg::E_NONE;

    case (mode_r)
      cst_pkg::M_OP1: begin
        if ((held_r == "/") && (src_byte == "/")) begin
          mode_nxt = cst_pkg::M_LINE;
        end else if ((held_r == "/") && (src_byte == "*")) begin
          mode_nxt = cst_pkg::M_BLOCK;
        end else if (((held_r == "<") || (held_r == ">")) && (src_byte == held_r)) begin
          mode_nxt = cst_pkg::M_OP2;
        end else begin
          mode_nxt = cst_pkg::M_IDLE;
          c_v      = 1'b1;
          if (dbl[7]) begin
            c_kind = dbl[6:0];
            c_len  = n_in;
          end else begin
            c_kind = cst_pkg::op_single(held_r);
            c_len  = SPAN_W'(1);
            again  = 1'b1;
          end
        end
      end
      cst_pkg::M_OP2: begin
        mode_nxt = cst_pkg::M_IDLE;
        c_v      = 1'b1;
        if (src_byte == "=") begin
          c_kind = (held_r == "<") ? cst_pkg::K_SHLEQ : cst_pkg::K_SHREQ;
          c_len  = n_in;
        end else begin
          c_kind = (held_r == "<") ? cst_pkg::K_SHL : cst_pkg::K_SHR;
          again  = 1'b1;
        end
      end
      cst_pkg::M_DEC, cst_pkg::M_ZERO, cst_pkg::M_OCT, cst_pkg::M_HEX: begin
        if ((mode_r == cst_pkg::M_ZERO) && ((src_byte == "x") || (src_byte == "X"))) begin
          mode_nxt = cst_pkg::M_HEX;
        end else if (((mode_r == cst_pkg::M_ZERO) || (mode_r == cst_pkg::M_OCT)) &&
                     cst_pkg::is_oct(src_byte)) begin
          mode_nxt = cst_pkg::M_OCT;
        end else if (((mode_r == cst_pkg::M_DEC) && cst_pkg::is_dec(src_byte)) ||
                     ((mode_r == cst_pkg::M_HEX) && cst_pkg::is_hex(src_byte))) begin
          mode_nxt = mode_r;
        end else begin
          c_v      = 1'b1;
          c_kind   = cst_pkg::K_NUM;
          mode_nxt = cst_pkg::M_IDLE;
          again    = 1'b1;
        end
      end
      cst_pkg::M_IDENT: begin
        if (cst_pkg::is_alpha(src_byte) || cst_pkg::is_dec(src_byte)) begin
          if (n_ex < SPAN_W'(KEYWORD_MAX_CHARS)) begin
            buf_we  = 1'b1;
            buf_idx = n_ex[$clog2(KEYWORD_MAX_CHARS)-1:0];
          end else begin
            too_long_nxt = 1'b1;
          end
        end else begin
          c_v      = 1'b1;
          c_kind   = kw_kind;
          mode_nxt = cst_pkg::M_IDLE;
          again    = 1'b1;
        end
      end
      cst_pkg::M_STR, cst_pkg::M_CHR: begin
        if (src_byte == 8'h00) begin
          c_v      = 1'b1;
          c_kind   = (mode_r == cst_pkg::M_STR) ? cst_pkg::K_STR : cst_pkg::K_CH;
          c_err    = cst_pkg::E_UNTERM;
          mode_nxt = cst_pkg::M_IDLE;
          again    = 1'b1;
        end else if ((mode_r == cst_pkg::M_STR) && (src_byte == "\"")) begin
          c_v      = 1'b1;
          c_kind   = cst_pkg::K_STR;
          c_len    = n_in;
          mode_nxt = cst_pkg::M_IDLE;
        end else if ((mode_r == cst_pkg::M_CHR) && (src_byte == "'")) begin
          c_v      = 1'b1;
          c_kind   = cst_pkg::K_CH;
          c_len    = n_in;
          c_err    = (n_in == SPAN_W'(2)) ? cst_pkg::E_EMPTY : cst_pkg::E_NONE;
          mode_nxt = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_LINE: begin
        if (src_byte == "\n") begin
          mode_nxt = cst_pkg::M_IDLE;
        end else if (src_byte == 8'h00) begin
          mode_nxt = cst_pkg::M_IDLE;
          again    = 1'b1;
        end
      end
      cst_pkg::M_BLOCK, cst_pkg::M_STAR: begin
        if (src_byte == 8'h00) begin
          blk_open_nxt = 1'b1;
          mode_nxt     = cst_pkg::M_IDLE;
          again        = 1'b1;
        end else if ((mode_r == cst_pkg::M_STAR) && (src_byte == "/")) begin
          mode_nxt = cst_pkg::M_IDLE;
        end else begin
          mode_nxt = (src_byte == "*") ? cst_pkg::M_STAR : cst_pkg::M_BLOCK;
        end
      end
      default: begin
        mode_nxt = cst_pkg::M_IDLE;
        again    = 1'b1;
      end
    endcase

    // Start a token from this byte
    if (again) begin
      case (src_byte)
        8'h00: begin
          s_v   = 1'b1;
          s_kind = cst_pkg::K_EOF;
          s_len = '0;
          s_err = blk_open_nxt ? cst_pkg::E_UNTERM : cst_pkg::E_NONE;
          ended = 1'b1;
        end
        "\t", "\n", " ": begin
          s_v = 1'b0;
        end
        "#": begin s_v = 1'b1; s_kind = cst_pkg::K_HASH;   end
        "(": begin s_v = 1'b1; s_kind = cst_pkg::K_LPAREN; end
        ")": begin s_v = 1'b1; s_kind = cst_pkg::K_RPAREN; end
        "[": begin s_v = 1'b1; s_kind = cst_pkg::K_LBRACK; end
        "]": begin s_v = 1'b1; s_kind = cst_pkg::K_RBRACK; end
        "{": begin s_v = 1'b1; s_kind = cst_pkg::K_LBRACE; end
        "}": begin s_v = 1'b1; s_kind = cst_pkg::K_RBRACE; end
        ":": begin s_v = 1'b1; s_kind = cst_pkg::K_COLON;  end
        ";": begin s_v = 1'b1; s_kind = cst_pkg::K_SEMI;   end
        ".": begin s_v = 1'b1; s_kind = cst_pkg::K_DOT;    end
        ",": begin s_v = 1'b1; s_kind = cst_pkg::K_COMMA;  end
        "\"": begin
          mode_nxt  = cst_pkg::M_STR;
          start_nxt = pos_r;
        end
        "'": begin
          mode_nxt  = cst_pkg::M_CHR;
          start_nxt = pos_r;
        end
        default: begin
          start_nxt = pos_r;
          if (cst_pkg::is_op_start(src_byte)) begin
            mode_nxt = cst_pkg::M_OP1;
            held_nxt = src_byte;
          end else if (cst_pkg::is_dec(src_byte)) begin
            mode_nxt = (src_byte == "0") ? cst_pkg::M_ZERO : cst_pkg::M_DEC;
          end else if (cst_pkg::is_alpha(src_byte)) begin
            mode_nxt     = cst_pkg::M_IDENT;
            buf_we       = 1'b1;
            buf_idx      = '0;
            too_long_nxt = 1'b0;
          end else begin
            s_v    = 1'b1;
            s_kind = cst_pkg::K_ILLEGAL;
            s_err  = cst_pkg::E_UNKNOWN;
          end
        end
      endcase
    end

    // Advance position, or drop everything at end of input
    if (ended) begin
      mode_nxt     = cst_pkg::M_IDLE;
      held_nxt     = '0;
      pos_nxt      = '0;
      start_nxt    = '0;
      too_long_nxt = 1'b0;
      blk_open_nxt = 1'b0;
    end else begin
      pos_nxt = pos_r + POSITION_BITS'(1);
    end
  end

  // Pack results: the closed token goes first, last flag on the final one
  always_comb begin
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    res0       = '0;
    res1       = '0;
    if (step) begin
      if (c_v) begin
        push.push0 = 1'b1;
        push.push1 = s_v;
        res0 = {c_kind, c_start, sat(c_len), c_err, !s_v};
        res1 = {s_kind, pos_r, sat(s_len), s_err, 1'b1};
      end else if (s_v) begin
        push.push0 = 1'b1;
        res0 = {s_kind, pos_r, sat(s_len), s_err, 1'b1};
      end
    end
  end

  // Hold lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= cst_pkg::M_IDLE;
      held_r     <= '0;
      pos_r      <= '0;
      start_r    <= '0;
      too_long_r <= 1'b0;
      blk_open_r <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      too_long_r <= too_long_nxt;
      blk_open_r <= blk_open_nxt;
    end
  end

  // Capture identifier characters
  always_ff @(posedge clk) begin
    if (step && buf_we) begin
      buf_r[buf_idx] <= src_byte;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cst_out_fifo.sv */
// Small result queue taking up to two words per cycle and giving one while out_ready is high.
// Depends on cst_pkg for depth and the push control struct.
`default_nettype none
module cst_out_fifo #(
  parameter int WIDTH = 58
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cst_pkg::push_t   push,
  input  wire logic [WIDTH-1:0] din0,
  input  wire logic [WIDTH-1:0] din1,
  output logic                  room2,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] dout
);

  localparam int AW = cst_pkg::FIFO_AW;
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem [cst_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             pop;
  logic [CW-1:0]    n_push;

  assign out_valid = (cnt_r != '0);
  assign dout      = mem[rd_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= CW'(cst_pkg::FIFO_DEPTH - 2));
  assign n_push    = CW'(push.push0) + CW'(push.push1);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(n_push);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= cnt_r + n_push - CW'(pop);
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_r] <= din0;
    end
    if (push.push1) begin
      mem[wr_r + AW'(1)] <= din1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(cst_pkg::FIFO_DEPTH)) else $error("result queue overflow");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0) else $error("second word pushed without first");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push0 || push.push1) |-> room2) else $error("push without room");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!push.push0 && !pop) |=> $stable(cnt_r)) else $error("count moved while idle");

endmodule
`default_nettype wire

/* hw/rtl/c_source_tokenizer.sv */
// C source tokenizer
//
// Input channel: one source byte per word on in_source_byte (in_valid /
// in_ready); byte 0 marks end of input. Output channel: one token per word
// (kind, start offset, length, error code, last_of_run) on out_valid /
// out_ready. A byte produces zero, one or two tokens; last_of_run marks the
// final token a byte produced.
// Path: a byte is registered in the input register, then lexed into the result
// queue, which registers its tokens before they are visible on the output.
// Throughput: one byte per cycle while the queue has room; the lexer state register is
// updated once per byte and the keyword compare runs in parallel in that
// same cycle. A four-word result queue absorbs bytes that give two tokens;
// the input stalls when the queue holds more than two tokens.
// Reset (rst_n low, synchronous) returns the lexer to idle at offset zero
// and empties the queue. End of input resets offsets for the next source.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost or repeated.
`default_nettype none
module c_source_tokenizer #(
  parameter int POSITION_BITS     = cst_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS       = cst_pkg::LENGTH_BITS_DEF,
  parameter int KEYWORD_MAX_CHARS = cst_pkg::KEYWORD_MAX_CHARS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_source_byte,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [6:0]               out_token_kind,
  output logic      [POSITION_BITS-1:0] out_start_offset,
  output logic      [LENGTH_BITS-1:0]   out_token_length,
  output logic      [1:0]               out_error_code,
  output logic                          out_last_of_run
);

  localparam int RES_W = cst_pkg::KIND_BITS + POSITION_BITS + LENGTH_BITS +
                         cst_pkg::ERR_BITS + 1;

  logic             s1_v_r;
  logic [7:0]       s1_byte_r;
  logic             step;
  logic             room2;
  cst_pkg::push_t   push;
  logic [RES_W-1:0] res0, res1, dout;

  assign step     = s1_v_r && room2;
  assign in_ready = !s1_v_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_source_byte;
    end
  end

  cst_lexer #(
    .POSITION_BITS     (POSITION_BITS),
    .LENGTH_BITS       (LENGTH_BITS),
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .src_byte (s1_byte_r),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  cst_out_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign {out_token_kind, out_start_offset, out_token_length,
          out_error_code, out_last_of_run} = dout;

endmodule
`default_nettype wire
